// ===== design/rotary_encoder_button_qualifier_assert.svh =====
// ----------------------------------------------------------------------------
// Rotary encoder button qualifier: assertion macros
// Shared property forms for the checker, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ROTARY_ENCODER_BUTTON_QUALIFIER_ASSERT_SVH
`define ROTARY_ENCODER_BUTTON_QUALIFIER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define REBQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define REBQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rebq_pkg.sv =====
// ----------------------------------------------------------------------------
// rebq_pkg
// Shared types, register codes and defaults of the encoder button qualifier.
// ----------------------------------------------------------------------------
`default_nettype none

package rebq_pkg;

  localparam int TIMER_WIDTH_DEF    = 16;
  localparam int POSITION_WIDTH_DEF = 32;

  localparam int EPS_W      = 4;
  localparam int DEBOUNCE_W = 8;
  localparam int LONG_W     = 16;
  localparam int LOCKOUT_W  = 10;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  // Register indexes (word address paddr[3:2]).
  localparam logic [1:0] REG_EDGES    = 2'd0;
  localparam logic [1:0] REG_DEBOUNCE = 2'd1;
  localparam logic [1:0] REG_LONG     = 2'd2;
  localparam logic [1:0] REG_LOCKOUT  = 2'd3;

  localparam logic [EPS_W-1:0]      EDGES_RST    = 4'd2;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 8'd50;
  localparam logic [LONG_W-1:0]     LONG_RST     = 16'd1000;
  localparam logic [LOCKOUT_W-1:0]  LOCKOUT_RST  = 10'd150;

  typedef struct packed {
    logic [EPS_W-1:0]      edges_per_step;
    logic [DEBOUNCE_W-1:0] debounce_ticks;
    logic [LONG_W-1:0]     long_press_ticks;
    logic [LOCKOUT_W-1:0]  lockout_ticks;
  } cfg_t;

  typedef struct packed {
    logic button_level;
    logic take_click;
    logic take_long_press;
  } btn_in_t;

  typedef struct packed {
    logic click_taken;
    logic long_press_taken;
    logic button_stable;
    logic click_waiting;
    logic long_press_waiting;
  } btn_res_t;

endpackage

`default_nettype wire

// ===== design/rebq_enc.sv =====
// ----------------------------------------------------------------------------
// rebq_enc
// Quadrature edge accumulator and wrapping step position, one tick per enable.
// ----------------------------------------------------------------------------
`default_nettype none

module rebq_enc #(
  parameter int POSITION_WIDTH = rebq_pkg::POSITION_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        clk_level,
  input  wire logic                        dt_level,
  input  wire logic                        load_position,
  input  wire logic signed [31:0]          new_position,
  input  wire logic [rebq_pkg::EPS_W-1:0]  edges_per_step,
  output logic signed [31:0]               position_nxt
);
  import rebq_pkg::*;

  logic                      last_clk_r, last_clk_nxt;
  logic signed [4:0]         accum_r, accum_nxt;
  logic [POSITION_WIDTH-1:0] pos_r, pos_nxt;

  logic signed [5:0]  eps;
  logic signed [5:0]  acc;
  logic signed [63:0] load_ext;
  logic [63:0]        pos_wide;

  always_comb begin
    eps          = (edges_per_step == '0) ? 6'sd1 : signed'({2'b00, edges_per_step});
    acc          = 6'(accum_r) + ((dt_level != clk_level) ? 6'sd1 : -6'sd1);
    load_ext     = 64'(new_position);
    last_clk_nxt = last_clk_r;
    accum_nxt    = accum_r;
    pos_nxt      = pos_r;
    if (clk_level != last_clk_r) begin
      last_clk_nxt = clk_level;
      if (acc >= eps) begin
        pos_nxt   = pos_r + POSITION_WIDTH'(1);
        accum_nxt = 5'(acc - eps);
      end else if (acc <= -eps) begin
        pos_nxt   = pos_r - POSITION_WIDTH'(1);
        accum_nxt = 5'(acc + eps);
      end else begin
        accum_nxt = 5'(acc);
      end
    end
    if (load_position) begin
      pos_nxt = load_ext[POSITION_WIDTH-1:0];
    end
    pos_wide     = 64'(pos_nxt);
    position_nxt = signed'(pos_wide[31:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_clk_r <= 1'b1;
      accum_r    <= '0;
      pos_r      <= '0;
    end else if (en) begin
      last_clk_r <= last_clk_nxt;
      accum_r    <= accum_nxt;
      pos_r      <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/rebq_btn.sv =====
// ----------------------------------------------------------------------------
// rebq_btn
// Switch edge capture, polled debounce, long-press detection and consumes.
// ----------------------------------------------------------------------------
`default_nettype none

module rebq_btn #(
  parameter int TIMER_WIDTH = rebq_pkg::TIMER_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire rebq_pkg::cfg_t    cfg,
  input  wire rebq_pkg::btn_in_t btn_in,
  output rebq_pkg::btn_res_t     btn_res
);
  import rebq_pkg::*;

  localparam logic [TIMER_WIDTH-1:0] TMAX = '1;

  logic                   last_raw_r, last_raw_nxt;
  logic                   stable_r, stable_nxt;
  logic [TIMER_WIDTH-1:0] since_raw_r, since_raw_nxt;
  logic [TIMER_WIDTH-1:0] press_el_r, press_el_nxt;
  logic [TIMER_WIDTH-1:0] since_click_r, since_click_nxt;
  logic                   press_act_r, press_act_nxt;
  logic                   long_rep_r, long_rep_nxt;
  logic                   click_flag_r, click_flag_nxt;
  logic                   long_flag_r, long_flag_nxt;
  logic                   pending_r, pending_nxt;
  logic [LOCKOUT_W-1:0]   lockout_r, lockout_nxt;
  logic                   click_taken, long_taken;
  logic                   raw;

  always_comb begin
    raw         = btn_in.button_level;
    click_taken = 1'b0;
    long_taken  = 1'b0;

    // Timers advance first; all up-counters stick at full scale.
    lockout_nxt     = (lockout_r != '0) ? lockout_r - LOCKOUT_W'(1) : lockout_r;
    since_raw_nxt   = (since_raw_r == TMAX) ? since_raw_r : since_raw_r + TIMER_WIDTH'(1);
    since_click_nxt = (since_click_r == TMAX) ? since_click_r
                                              : since_click_r + TIMER_WIDTH'(1);
    press_el_nxt    = (press_act_r && press_el_r != TMAX) ? press_el_r + TIMER_WIDTH'(1)
                                                          : press_el_r;
    last_raw_nxt   = last_raw_r;
    stable_nxt     = stable_r;
    press_act_nxt  = press_act_r;
    long_rep_nxt   = long_rep_r;
    click_flag_nxt = click_flag_r;
    long_flag_nxt  = long_flag_r;
    pending_nxt    = pending_r;

    // Raw falling edge raises a click outside the lockout window when no event is pending.
    if (!raw && last_raw_r && !pending_r && lockout_nxt == '0) begin
      click_flag_nxt = 1'b1;
      pending_nxt    = 1'b1;
      lockout_nxt    = cfg.lockout_ticks;
    end

    if (raw != last_raw_r) begin
      since_raw_nxt = '0;
      last_raw_nxt  = raw;
    end

    if (32'(since_raw_nxt) > 32'(cfg.debounce_ticks)) begin
      if (raw != stable_r) begin
        stable_nxt = raw;
        if (!raw) begin
          press_act_nxt = 1'b1;
          press_el_nxt  = '0;
          long_rep_nxt  = 1'b0;
        end else begin
          if (!long_flag_nxt && !click_flag_nxt) begin
            pending_nxt    = 1'b0;
            click_flag_nxt = 1'b0;
          end
          press_act_nxt = 1'b0;
          long_rep_nxt  = 1'b0;
        end
      end
      if (!stable_nxt && !long_rep_nxt && press_act_nxt &&
          32'(press_el_nxt) >= 32'(cfg.long_press_ticks)) begin
        long_flag_nxt  = 1'b1;
        click_flag_nxt = 1'b0;
        long_rep_nxt   = 1'b1;
      end
    end

    if (btn_in.take_click && 32'(since_click_nxt) > 32'(cfg.debounce_ticks) &&
        !long_flag_nxt && click_flag_nxt) begin
      click_flag_nxt  = 1'b0;
      pending_nxt     = 1'b0;
      lockout_nxt     = '0;
      since_click_nxt = '0;
      click_taken     = 1'b1;
    end
    if (btn_in.take_long_press && long_flag_nxt) begin
      long_flag_nxt  = 1'b0;
      click_flag_nxt = 1'b0;
      pending_nxt    = 1'b0;
      lockout_nxt    = '0;
      long_taken     = 1'b1;
    end

    btn_res.click_taken        = click_taken;
    btn_res.long_press_taken   = long_taken;
    btn_res.button_stable      = stable_nxt;
    btn_res.click_waiting      = click_flag_nxt;
    btn_res.long_press_waiting = long_flag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r    <= 1'b1;
      stable_r      <= 1'b1;
      since_raw_r   <= '0;
      press_el_r    <= '0;
      since_click_r <= '0;
      press_act_r   <= 1'b0;
      long_rep_r    <= 1'b0;
      click_flag_r  <= 1'b0;
      long_flag_r   <= 1'b0;
      pending_r     <= 1'b0;
      lockout_r     <= '0;
    end else if (en) begin
      last_raw_r    <= last_raw_nxt;
      stable_r      <= stable_nxt;
      since_raw_r   <= since_raw_nxt;
      press_el_r    <= press_el_nxt;
      since_click_r <= since_click_nxt;
      press_act_r   <= press_act_nxt;
      long_rep_r    <= long_rep_nxt;
      click_flag_r  <= click_flag_nxt;
      long_flag_r   <= long_flag_nxt;
      pending_r     <= pending_nxt;
      lockout_r     <= lockout_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/rotary_encoder_button_qualifier.sv =====
// ----------------------------------------------------------------------------
// Rotary encoder button qualifier
// Turns pin samples into a step position and qualified click events.
// ----------------------------------------------------------------------------
// Usage: send one word per sample tick on the in_ channel (encoder pins, switch
// pin, consume strobes, optional position load). Every input word yields
// exactly one result word on the out_ channel: the position after the tick,
// the consume results, the debounced switch level and the pending flags.
// A word goes into an input register at acceptance and its result moves into
// the output register when that register is empty or being read. The block
// takes one word per cycle while the receiver keeps up; the tick update is
// computed combinationally from the state registers, which sets that rate.
// When the receiver stalls, the result is held and the input register still
// fills; in_ready drops only when both registers are full and out_ready low.
// Reset (rst_n low, synchronous) empties both registers, restores the
// register defaults (2, 50, 1000, 150) and the idle state (pins high, no
// events, position zero). Registers sit at APB byte addresses 0, 4, 8 and 12;
// the user writes them only while the block is idle; nothing enforces it.
// ----------------------------------------------------------------------------
`default_nettype none

module rotary_encoder_button_qualifier #(
  parameter int TIMER_WIDTH    = rebq_pkg::TIMER_WIDTH_DEF,
  parameter int POSITION_WIDTH = rebq_pkg::POSITION_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_clk_level,
  input  wire logic                         in_dt_level,
  input  wire logic                         in_button_level,
  input  wire logic                         in_take_click,
  input  wire logic                         in_take_long_press,
  input  wire logic                         in_load_position,
  input  wire logic signed [31:0]           in_new_position,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [31:0]                out_position,
  output logic                              out_click_taken,
  output logic                              out_long_press_taken,
  output logic                              out_button_stable,
  output logic                              out_click_waiting,
  output logic                              out_long_press_waiting,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [rebq_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [rebq_pkg::DATA_W-1:0]  pwdata,
  output logic [rebq_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);
  import rebq_pkg::*;

  cfg_t cfg_r;

  logic               s0_valid_r;
  logic               s0_clk_r, s0_dt_r, s0_load_r;
  btn_in_t            s0_btn_r;
  logic signed [31:0] s0_newpos_r;
  logic               out_valid_r;
  logic signed [31:0] position_nxt;
  btn_res_t           btn_res, res_r;
  logic signed [31:0] position_r;
  logic               adv;
  logic               wr_en;

  // The tick is applied when the input word moves into the result register.
  assign adv      = s0_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s0_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s0_valid_r <= 1'b1;
      end else if (adv) begin
        s0_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_clk_r    <= in_clk_level;
      s0_dt_r     <= in_dt_level;
      s0_load_r   <= in_load_position;
      s0_newpos_r <= in_new_position;
      s0_btn_r    <= '{button_level: in_button_level, take_click: in_take_click,
                       take_long_press: in_take_long_press};
    end
    if (adv) begin
      position_r <= position_nxt;
      res_r      <= btn_res;
    end
  end

  rebq_enc #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_enc (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (adv),
    .clk_level     (s0_clk_r),
    .dt_level      (s0_dt_r),
    .load_position (s0_load_r),
    .new_position  (s0_newpos_r),
    .edges_per_step(cfg_r.edges_per_step),
    .position_nxt  (position_nxt)
  );

  rebq_btn #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_btn (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .cfg    (cfg_r),
    .btn_in (s0_btn_r),
    .btn_res(btn_res)
  );

  assign out_valid              = out_valid_r;
  assign out_position           = position_r;
  assign out_click_taken        = res_r.click_taken;
  assign out_long_press_taken   = res_r.long_press_taken;
  assign out_button_stable      = res_r.button_stable;
  assign out_click_waiting      = res_r.click_waiting;
  assign out_long_press_waiting = res_r.long_press_waiting;

  // Configuration port.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{edges_per_step: EDGES_RST, debounce_ticks: DEBOUNCE_RST,
                 long_press_ticks: LONG_RST, lockout_ticks: LOCKOUT_RST};
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_EDGES:    cfg_r.edges_per_step   <= pwdata[EPS_W-1:0];
        REG_DEBOUNCE: cfg_r.debounce_ticks   <= pwdata[DEBOUNCE_W-1:0];
        REG_LONG:     cfg_r.long_press_ticks <= pwdata[LONG_W-1:0];
        REG_LOCKOUT:  cfg_r.lockout_ticks    <= pwdata[LOCKOUT_W-1:0];
        default:      cfg_r                  <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_EDGES:    prdata = DATA_W'(cfg_r.edges_per_step);
      REG_DEBOUNCE: prdata = DATA_W'(cfg_r.debounce_ticks);
      REG_LONG:     prdata = DATA_W'(cfg_r.long_press_ticks);
      REG_LOCKOUT:  prdata = DATA_W'(cfg_r.lockout_ticks);
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/rebq_checker.sv =====
// ----------------------------------------------------------------------------
// rebq_checker
// Port-level checks on the result channel of the encoder button qualifier.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rotary_encoder_button_qualifier_assert.svh"

module rebq_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_position,
  input wire logic        out_click_taken,
  input wire logic        out_long_press_taken,
  input wire logic        out_click_waiting,
  input wire logic        out_long_press_waiting
);

  // A stalled result word must not move.
  `REBQ_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_position), "result changed while stalled")

  // A click and a long press are never both taken in one result word.
  `REBQ_ASSERT_NOW(a_one_take, out_valid, !(out_click_taken && out_long_press_taken), "click and long press taken together")

  `REBQ_ASSERT_NOW(a_click_clear, out_valid && out_click_taken, !out_click_waiting, "click still waiting after it was taken")

  `REBQ_ASSERT_NOW(a_long_clear, out_valid && out_long_press_taken, !out_long_press_waiting && !out_click_waiting, "flags still set after long press taken")

endmodule

bind rotary_encoder_button_qualifier rebq_checker u_rebq_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .out_position          (out_position),
  .out_click_taken       (out_click_taken),
  .out_long_press_taken  (out_long_press_taken),
  .out_click_waiting     (out_click_waiting),
  .out_long_press_waiting(out_long_press_waiting)
);

`default_nettype wire

// ===== tb/tb_rotary_encoder_button_qualifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rotary_encoder_button_qualifier
// Self-checking bench for the encoder button qualifier. A driver feeds sample
// ticks from a queue, a monitor predicts each result word with its own model
// of the encoder, debounce and click logic, and compares every output field.
// Phases change the registers over APB and vary source and sink throttling.
// ----------------------------------------------------------------------------
module tb_rotary_encoder_button_qualifier;
  import rebq_pkg::*;

  localparam int STUCK_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 4;

  typedef logic [TIMER_WIDTH_DEF-1:0] timer_t;

  typedef struct {
    logic               clk_lv;
    logic               dt_lv;
    logic               btn_lv;
    logic               take_click;
    logic               take_long;
    logic               load;
    logic signed [31:0] new_pos;
  } tick_word_t;

  typedef struct {
    logic signed [31:0] position;
    btn_res_t           flags;
  } tick_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_clk_level;
  logic               in_dt_level;
  logic               in_button_level;
  logic               in_take_click;
  logic               in_take_long_press;
  logic               in_load_position;
  logic signed [31:0] in_new_position;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_position;
  logic               out_click_taken;
  logic               out_long_press_taken;
  logic               out_button_stable;
  logic               out_click_waiting;
  logic               out_long_press_waiting;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  rotary_encoder_button_qualifier dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_clk_level           (in_clk_level),
    .in_dt_level            (in_dt_level),
    .in_button_level        (in_button_level),
    .in_take_click          (in_take_click),
    .in_take_long_press     (in_take_long_press),
    .in_load_position       (in_load_position),
    .in_new_position        (in_new_position),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_position           (out_position),
    .out_click_taken        (out_click_taken),
    .out_long_press_taken   (out_long_press_taken),
    .out_button_stable      (out_button_stable),
    .out_click_waiting      (out_click_waiting),
    .out_long_press_waiting (out_long_press_waiting),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready)
  );

  tick_word_t   tick_queue[$];
  tick_result_t predicted_results[$];
  int           send_idle_pct;
  int           recv_stall_pct;
  int           mismatches;
  int           stuck_cycles;
  int           words_queued;
  bit           word_taken;

  // Predictor copy of the registers and the tick state.
  cfg_t                 cfg_shadow;
  logic                 last_clk;
  logic                 last_raw;
  logic                 stable_btn;
  int                   edge_acc;
  logic [31:0]          pos;
  timer_t               since_raw;
  timer_t               press_time;
  timer_t               since_click;
  logic [LOCKOUT_W-1:0] lock_left;
  bit                   press_active;
  bit                   long_reported;
  bit                   click_flag;
  bit                   long_flag;
  bit                   event_pending;

  // Stimulus generator state.
  logic gen_clk;
  logic gen_dt;
  logic spin_up;
  int   gen_deb;
  int   gen_lng;
  int   gen_lock;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic timer_t sat_inc(input timer_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  task automatic reset_model();
    cfg_shadow.edges_per_step   = EDGES_RST;
    cfg_shadow.debounce_ticks   = DEBOUNCE_RST;
    cfg_shadow.long_press_ticks = LONG_RST;
    cfg_shadow.lockout_ticks    = LOCKOUT_RST;
    last_clk      = 1'b1;
    last_raw      = 1'b1;
    stable_btn    = 1'b1;
    edge_acc      = 0;
    pos           = '0;
    since_raw     = '0;
    press_time    = '0;
    since_click   = '0;
    lock_left     = '0;
    press_active  = 1'b0;
    long_reported = 1'b0;
    click_flag    = 1'b0;
    long_flag     = 1'b0;
    event_pending = 1'b0;
  endtask

  task automatic predict_tick(input tick_word_t w, output tick_result_t r);
    int eps;
    int acc;
    r.position = '0;
    r.flags    = '0;
    eps = (cfg_shadow.edges_per_step == '0) ? 1 : int'(cfg_shadow.edges_per_step);

    if (lock_left != '0) lock_left = lock_left - 1'b1;
    since_raw   = sat_inc(since_raw);
    since_click = sat_inc(since_click);
    if (press_active) press_time = sat_inc(press_time);

    if (w.clk_lv != last_clk) begin
      last_clk = w.clk_lv;
      acc = edge_acc + ((w.dt_lv != w.clk_lv) ? 1 : -1);
      if (acc >= eps) begin
        pos = pos + 1'b1;
        acc = acc - eps;
      end else if (acc <= -eps) begin
        pos = pos - 1'b1;
        acc = acc + eps;
      end
      edge_acc = acc;
    end

    // A raw falling edge qualifies a click right away, before any debounce.
    if (!w.btn_lv && last_raw && !event_pending && lock_left == '0) begin
      click_flag    = 1'b1;
      event_pending = 1'b1;
      lock_left     = cfg_shadow.lockout_ticks;
    end

    if (w.btn_lv != last_raw) begin
      since_raw = '0;
      last_raw  = w.btn_lv;
    end
    if (since_raw > cfg_shadow.debounce_ticks) begin
      if (w.btn_lv != stable_btn) begin
        stable_btn = w.btn_lv;
        if (!stable_btn) begin
          press_active  = 1'b1;
          press_time    = '0;
          long_reported = 1'b0;
        end else begin
          if (!long_flag && !click_flag) begin
            event_pending = 1'b0;
            click_flag    = 1'b0;
          end
          press_active  = 1'b0;
          long_reported = 1'b0;
        end
      end
      if (!stable_btn && !long_reported && press_active &&
          press_time >= cfg_shadow.long_press_ticks) begin
        long_flag     = 1'b1;
        click_flag    = 1'b0;
        long_reported = 1'b1;
      end
    end

    if (w.take_click && since_click > cfg_shadow.debounce_ticks && !long_flag && click_flag) begin
      click_flag    = 1'b0;
      event_pending = 1'b0;
      lock_left     = '0;
      since_click   = '0;
      r.flags.click_taken = 1'b1;
    end
    if (w.take_long && long_flag) begin
      long_flag     = 1'b0;
      click_flag    = 1'b0;
      event_pending = 1'b0;
      lock_left     = '0;
      r.flags.long_press_taken = 1'b1;
    end

    if (w.load) pos = w.new_pos;

    r.position                 = pos;
    r.flags.button_stable      = stable_btn;
    r.flags.click_waiting      = click_flag;
    r.flags.long_press_waiting = long_flag;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Monitor: predicts on input acceptance, checks on output acceptance.
  always @(posedge clk) begin : monitor
    tick_word_t   w;
    tick_result_t want;
    bit           busy;
    if (!rst_n) begin
      reset_model();
      word_taken   = 1'b0;
      stuck_cycles = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_EDGES:    cfg_shadow.edges_per_step   = pwdata[EPS_W-1:0];
          REG_DEBOUNCE: cfg_shadow.debounce_ticks   = pwdata[DEBOUNCE_W-1:0];
          REG_LONG:     cfg_shadow.long_press_ticks = pwdata[LONG_W-1:0];
          REG_LOCKOUT:  cfg_shadow.lockout_ticks    = pwdata[LOCKOUT_W-1:0];
          default: ;
        endcase
      end

      word_taken = in_valid && in_ready;
      if (word_taken) begin
        w.clk_lv     = in_clk_level;
        w.dt_lv      = in_dt_level;
        w.btn_lv     = in_button_level;
        w.take_click = in_take_click;
        w.take_long  = in_take_long_press;
        w.load       = in_load_position;
        w.new_pos    = in_new_position;
        predict_tick(w, want);
        predicted_results.push_back(want);
      end

      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          $error("result word arrived with nothing predicted");
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          check_field("position", want.position, out_position);
          check_field("click_taken", want.flags.click_taken, out_click_taken);
          check_field("long_press_taken", want.flags.long_press_taken, out_long_press_taken);
          check_field("button_stable", want.flags.button_stable, out_button_stable);
          check_field("click_waiting", want.flags.click_waiting, out_click_waiting);
          check_field("long_press_waiting", want.flags.long_press_waiting,
                      out_long_press_waiting);
        end
      end

      busy = tick_queue.size() != 0 || in_valid || predicted_results.size() != 0;
      if (!busy || word_taken || (out_valid && out_ready) || (psel && penable)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  // Driver: a word stays on the bus until the edge that accepts it.
  always @(negedge clk) begin : driver
    tick_word_t w;
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !word_taken) begin
      // Hold the current word.
    end else if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      w = tick_queue.pop_front();
      in_clk_level       <= w.clk_lv;
      in_dt_level        <= w.dt_lv;
      in_button_level    <= w.btn_lv;
      in_take_click      <= w.take_click;
      in_take_long_press <= w.take_long;
      in_load_position   <= w.load;
      in_new_position    <= w.new_pos;
      in_valid           <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  task automatic push_tick(input logic c, input logic d, input logic b, input logic tc,
                           input logic tl, input logic ld, input logic [31:0] np);
    tick_word_t w;
    w.clk_lv     = c;
    w.dt_lv      = d;
    w.btn_lv     = b;
    w.take_click = tc;
    w.take_long  = tl;
    w.load       = ld;
    w.new_pos    = np;
    tick_queue.push_back(w);
    words_queued++;
  endtask

  // One tick with the switch at btn; the encoder mostly turns in the spin_up
  // direction so that detents are actually reached.
  task automatic next_tick(input logic btn);
    int r;
    r = $urandom_range(99);
    if (r < 45) begin
      gen_clk = ~gen_clk;
      gen_dt  = gen_clk ^ spin_up;
      if ($urandom_range(99) < 15) gen_dt = 1'($urandom_range(1));
    end else if (r < 55) begin
      gen_dt = ~gen_dt;
    end
    push_tick(gen_clk, gen_dt, btn, $urandom_range(99) < 25, $urandom_range(99) < 25,
              $urandom_range(99) < 3, $urandom);
  endtask

  // Press and release with contact bounce; the hold is either too short to
  // pass the debounce, a plain click, or long enough for a long press.
  task automatic queue_gesture();
    int hold;
    int r;
    int n;
    spin_up = 1'($urandom_range(1));
    n = $urandom_range(3);
    repeat (n) begin
      next_tick(1'b0);
      next_tick(1'b1);
    end
    r = $urandom_range(99);
    if (r < 30) hold = $urandom_range(1, gen_deb + 1);
    else if (r < 70) hold = $urandom_range(gen_deb + 2, gen_deb + 1 + gen_lng);
    else hold = $urandom_range(gen_deb + gen_lng + 2, gen_deb + gen_lng + 8);
    repeat (hold) next_tick(1'b0);
    n = $urandom_range(2);
    repeat (n) begin
      next_tick(1'b1);
      next_tick(1'b0);
    end
    hold = $urandom_range(1, gen_deb + gen_lock + 6);
    repeat (hold) next_tick(1'b1);
  endtask

  task automatic random_items(input int count);
    int stop;
    stop = words_queued + count;
    while (words_queued < stop) begin
      if ($urandom_range(99) < 20) begin
        push_tick(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  $urandom);
      end else begin
        queue_gesture();
      end
    end
  endtask

  task automatic settle();
    do @(posedge clk);
    while (tick_queue.size() != 0 || in_valid || predicted_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(input int eps, input int deb, input int lng, input int lock,
                           input int send_pct, input int recv_pct);
    settle();
    reg_write(REG_EDGES, eps);
    reg_write(REG_DEBOUNCE, deb);
    reg_write(REG_LONG, lng);
    reg_write(REG_LOCKOUT, lock);
    gen_deb        = deb;
    gen_lng        = lng;
    gen_lock       = lock;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin : stimulus
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_clk_level       = 1'b1;
    in_dt_level        = 1'b1;
    in_button_level    = 1'b1;
    in_take_click      = 1'b0;
    in_take_long_press = 1'b0;
    in_load_position   = 1'b0;
    in_new_position    = '0;
    out_ready          = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    mismatches         = 0;
    words_queued       = 0;
    gen_clk            = 1'b1;
    gen_dt             = 1'b1;
    spin_up            = 1'b1;
    gen_deb            = DEBOUNCE_RST;
    gen_lng            = LONG_RST;
    gen_lock           = LOCKOUT_RST;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Register defaults: a step size of 2 per detent, and a click that the consume
    // guard refuses because its timer has not passed the debounce since reset.
    push_tick(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0);
    push_tick(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0);
    push_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0);
    push_tick(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0);
    push_tick(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0);
    push_tick(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0);

    configure(1, 1, 1, 3, 0, 0);
    // Position wraps in both directions.
    push_tick(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 32'h7FFF_FFFF);
    push_tick(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0);
    push_tick(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 32'h8000_0000);
    push_tick(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0);
    push_tick(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0);
    // Press while the earlier click is pending, consume it, then an idle consume.
    push_tick(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0);
    push_tick(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0);
    // Hold to a long press; a click consume is refused while it waits.
    repeat (3) push_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0);
    push_tick(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0);
    push_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 32'h0);
    push_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 32'h0);
    repeat (3) push_tick(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0);
    // Short click, bounce inside the lockout, release with the click consumed.
    push_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0);
    push_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0);
    push_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0);
    repeat (3) push_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 32'h0);
    gen_clk = 1'b0;
    gen_dt  = 1'b0;

    // Zero step size counts as one; zero long-press time fires on the press.
    configure(0, 0, 0, 0, 0, 0);
    random_items(120);

    configure($urandom_range(1, 6), $urandom_range(0, 6), $urandom_range(1, 20),
              $urandom_range(0, 12), 48, 0);
    random_items(120);

    configure($urandom_range(1, 6), $urandom_range(0, 6), $urandom_range(1, 20),
              $urandom_range(0, 12), 0, 48);
    random_items(120);

    configure($urandom_range(1, 6), $urandom_range(0, 6), $urandom_range(1, 20),
              $urandom_range(0, 12), 27, 27);
    random_items(120);

    // Largest register values: a step size of 15 per detent, a debounce that keeps
    // the bouncing press from changing the stable level, and the longest lockout.
    configure(15, 255, 65535, 1023, 0, 48);
    spin_up = 1'b1;
    repeat (40) next_tick(1'b1);
    repeat (10) begin
      next_tick(1'b0);
      next_tick(1'b1);
    end
    repeat (20) next_tick(1'b0);
    repeat (20) next_tick(1'b1);

    configure($urandom_range(1, 15), $urandom_range(0, 6), $urandom_range(1, 20),
              $urandom_range(0, 12), 0, 0);
    random_items(120);

    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/rebq_pkg.sv
design/rebq_enc.sv
design/rebq_btn.sv
design/rotary_encoder_button_qualifier.sv
design/rebq_checker.sv
tb/tb_rotary_encoder_button_qualifier.sv
